// ===== sv/csem_pkg.sv =====
// ---------------------------------------------------------------------------
// csem_pkg - shared types for the counting semaphore table
// Command codes, sequencer states and the result record.
// ---------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

  // Width of a process id on the ports.
  localparam int PidFieldW = 6;

  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_OPEN  = 3'd1,
    CMD_CLOSE = 3'd2,
    CMD_POST  = 3'd3,
    CMD_WAIT  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LINK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 status;
    logic                 woke_valid;
    logic [PidFieldW-1:0] woke_pid;
    logic                 caller_blocked;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/counting_semaphore_table.sv =====
// ---------------------------------------------------------------------------
// counting_semaphore_table - table of counting semaphores with FIFO waiters
// Init, open, close, post and wait on a table of semaphores, each with a
// saturating counter and a linked-list queue of waiting process ids.
// ---------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (in_valid / in_ready) with fields
// cmd, sem_id, initial_value and caller_pid. Every command produces exactly
// one result item on the output channel (out_valid / out_ready) carrying
// status, woke_valid, woke_pid and caller_blocked.
// The block works on one command at a time under a small sequencer. The
// semaphore records (count, queue head, queue tail) live in one RAM and the
// per-process queue links in a second RAM, both with registered reads; one
// shared increment/decrement unit updates the counter. out_valid rises once
// the command has passed the read, evaluate and done states; a post that
// wakes a waiter or a wait that queues its caller also passes a link state
// to read the link RAM or link in the caller. in_ready is high only while
// the sequencer is idle, so a command is taken only once the last is done.
// The result sits in an output register; the block goes back to idle as
// soon as it is loaded, so the next command is accepted while the result
// waits. A stalled receiver only holds the next result back.
// Reset clears the in-use flags and the sequencer at once; the in-use flag
// doubles as the valid bit of each semaphore record, so no clearing pass is
// needed and the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_table
  import csem_pkg::*;
#(
  parameter int NUM_SEMAPHORES = 32,
  parameter int MAX_PROCESSES  = 64,
  parameter int COUNT_WIDTH    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [5:0]  sem_id,
  input  wire logic [15:0] initial_value,
  input  wire logic [5:0]  caller_pid,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic             woke_valid,
  output logic [5:0]       woke_pid,
  output logic             caller_blocked
);

  localparam int SemAw  = $clog2(NUM_SEMAPHORES);
  localparam int PidAw  = $clog2(MAX_PROCESSES);
  // Link values run up to MAX_PROCESSES, which marks an empty queue or end of list.
  localparam int LinkW  = $clog2(MAX_PROCESSES + 1);
  localparam logic [LinkW-1:0] EmptyMark = LinkW'(MAX_PROCESSES);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [LinkW-1:0]       head;
    logic [LinkW-1:0]       tail;
  } sem_rec_t;

  // Sequencer and latched command.
  state_t              state, state_next;
  cmd_t                cmd_r;
  logic [5:0]          sid_r;
  logic [15:0]         ival_r;
  logic [5:0]          pid_r;
  result_t             res, res_next;
  logic [NUM_SEMAPHORES-1:0] in_use, in_use_next;

  // Memory ports.
  sem_rec_t            rec;
  sem_rec_t            sem_wdata;
  logic                sem_we;
  logic [SemAw-1:0]    sem_idx;
  logic [LinkW-1:0]    link_rdata;
  logic [LinkW-1:0]    link_wdata;
  logic [PidAw-1:0]    link_waddr;
  logic [PidAw-1:0]    link_raddr;
  logic                link_we;

  // Decoded conditions.
  logic                in_fire;
  logic                sid_ok;
  logic                pid_ok;
  logic                used;
  logic                head_ok;
  logic                tail_ok;
  logic                next_ok;
  logic                out_load;

  // Shared counter unit: decrement for wait, saturating increment for post.
  logic                alu_dec;
  logic [COUNT_WIDTH-1:0] alu_out;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign sem_idx  = SemAw'(sid_r);

  assign sid_ok   = (32'(sid_r) < NUM_SEMAPHORES);
  assign pid_ok   = (32'(pid_r) < MAX_PROCESSES);
  assign used     = sid_ok && in_use[sem_idx];
  assign head_ok  = (32'(rec.head) < MAX_PROCESSES);
  assign tail_ok  = (32'(rec.tail) < MAX_PROCESSES);
  assign next_ok  = (32'(link_rdata) < MAX_PROCESSES);

  // The head link is read every cycle; it is only used after a post reaches it.
  assign link_raddr = PidAw'(rec.head);

  assign alu_dec = (cmd_r == CMD_WAIT);
  always_comb begin
    if (alu_dec) begin
      alu_out = rec.count - COUNT_WIDTH'(1);
    end else if (&rec.count) begin
      alu_out = rec.count;
    end else begin
      alu_out = rec.count + COUNT_WIDTH'(1);
    end
  end

  csem_ram #(
    .WIDTH ($bits(sem_rec_t)),
    .DEPTH (NUM_SEMAPHORES)
  ) u_sem_ram (
    .clk   (clk),
    .we    (sem_we),
    .waddr (sem_idx),
    .wdata (sem_wdata),
    .raddr (sem_idx),
    .rdata (rec)
  );

  csem_ram #(
    .WIDTH (LinkW),
    .DEPTH (MAX_PROCESSES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      in_use <= in_use_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_t'(cmd);
      sid_r  <= sem_id;
      ival_r <= initial_value;
      pid_r  <= caller_pid;
    end
    res <= res_next;
    if (out_load) begin
      status         <= res.status;
      woke_valid     <= res.woke_valid;
      woke_pid       <= res.woke_pid;
      caller_blocked <= res.caller_blocked;
    end
  end

  always_comb begin
    state_next  = state;
    in_use_next = in_use;
    res_next    = res;
    sem_we      = 1'b0;
    sem_wdata   = rec;
    link_we     = 1'b0;
    link_waddr  = PidAw'(pid_r);
    link_wdata  = EmptyMark;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_READ;
        end
      end

      S_READ: begin
        state_next = S_EVAL;
      end

      S_EVAL: begin
        res_next   = '{status: 1'b1, woke_valid: 1'b0, woke_pid: '0, caller_blocked: 1'b0};
        state_next = S_DONE;
        if (sid_ok) begin
          case (cmd_r)
            CMD_INIT: begin
              if (!in_use[sem_idx]) begin
                in_use_next[sem_idx] = 1'b1;
                sem_we          = 1'b1;
                sem_wdata.count = COUNT_WIDTH'(ival_r);
                sem_wdata.head  = EmptyMark;
                sem_wdata.tail  = EmptyMark;
                res_next.status = 1'b0;
              end
            end
            CMD_OPEN: begin
              res_next.status = !used;
            end
            CMD_CLOSE: begin
              // The record is rewritten by the next init, so only the flag drops.
              if (used) begin
                in_use_next[sem_idx] = 1'b0;
                res_next.status      = 1'b0;
              end
            end
            CMD_POST: begin
              if (used) begin
                res_next.status = 1'b0;
                if (head_ok) begin
                  state_next = S_LINK;
                end else begin
                  sem_we          = 1'b1;
                  sem_wdata.count = alu_out;
                end
              end
            end
            CMD_WAIT: begin
              if (used) begin
                if (rec.count != '0) begin
                  sem_we          = 1'b1;
                  sem_wdata.count = alu_out;
                  res_next.status = 1'b0;
                end else if (pid_ok) begin
                  // The caller becomes the end of the list.
                  link_we         = 1'b1;
                  res_next.status = 1'b0;
                  state_next      = S_LINK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_LINK: begin
        state_next = S_DONE;
        sem_we     = 1'b1;
        if (cmd_r == CMD_POST) begin
          res_next.woke_valid = 1'b1;
          res_next.woke_pid   = PidFieldW'(rec.head);
          if (next_ok) begin
            sem_wdata.head = link_rdata;
          end else begin
            sem_wdata.head = EmptyMark;
            sem_wdata.tail = EmptyMark;
          end
        end else begin
          res_next.caller_blocked = 1'b1;
          if (tail_ok && head_ok) begin
            link_we    = 1'b1;
            link_waddr = PidAw'(rec.tail);
            link_wdata = LinkW'(pid_r);
          end else begin
            sem_wdata.head = LinkW'(pid_r);
          end
          sem_wdata.tail = LinkW'(pid_r);
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/csem_ram.sv =====
// ---------------------------------------------------------------------------
// csem_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
